>>> sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the sensor thermostat: segment tables,
// scaling constants, register indexes and controller/datapath interface.
// ----------------------------------------------------------------------------
package stt_pkg;

    // segment table of the voltage to temperature map
    localparam int SEG_N  = 11;
    localparam int SEG_IW = 4;

    localparam logic [10:0] SEG_V1 [SEG_N] = '{
        11'd1299, 11'd1247, 11'd1141, 11'd1034, 11'd925, 11'd816,
        11'd704, 11'd591, 11'd476, 11'd361, 11'd243
    };
    localparam logic [10:0] SEG_V2 [SEG_N] = '{
        11'd1252, 11'd1146, 11'd1039, 11'd931, 11'd821, 11'd710,
        11'd596, 11'd482, 11'd367, 11'd249, 11'd183
    };
    localparam logic signed [8:0] SEG_T1 [SEG_N] = '{
        -9'sd50, -9'sd40, -9'sd20, 9'sd0, 9'sd20, 9'sd40,
        9'sd60, 9'sd80, 9'sd100, 9'sd120, 9'sd140
    };
    localparam logic signed [8:0] SEG_T2 [SEG_N] = '{
        -9'sd41, -9'sd21, -9'sd1, 9'sd19, 9'sd39, 9'sd59,
        9'sd79, 9'sd99, 9'sd119, 9'sd139, 9'sd150
    };

    // mv = floor(avg * 825 / 256)
    localparam logic [9:0]  MV_SCALE = 10'd825;
    localparam logic [11:0] MV_LO    = 12'd183;
    localparam logic [11:0] MV_HI    = 12'd1299;
    localparam logic [9:0]  RAW_OOR  = 10'd255;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMP_OFFSET = 2'd0;
    localparam logic [1:0] CFG_UPPER_LIMIT = 2'd1;
    localparam logic [1:0] CFG_LOWER_LIMIT = 2'd2;

    localparam logic signed [7:0] RST_TEMP_OFFSET = 8'sd0;
    localparam logic signed [8:0] RST_UPPER_LIMIT = 9'sd35;
    localparam logic signed [8:0] RST_LOWER_LIMIT = 9'sd30;

    // controller to datapath commands
    typedef struct packed {
        logic acc;        // add accepted word to running sum
        logic avg;        // average the finished sum and clear it
        logic mul;        // scale average to millivolts
        logic seg;        // pick segment, register its coefficients
        logic num;        // form interpolation numerator
        logic div_start;  // launch the interpolation divider
        logic fin;        // offset, thermostat, load output word
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;       // next accepted word completes a reading
        logic div_done;   // divider finishes at this edge
        logic out_free;   // output register can take a word
    } t_sts;

endpackage

>>> sv/stt_div.sv
// ----------------------------------------------------------------------------
// stt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stt_div #(
    parameter int DW = 16,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0] rem_sh;
    logic        take;

    assign rem_sh = {r_rem, r_dvd[DW-1]};
    assign take   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_quo <= {r_quo[DW-2:0], take};
            if (take) begin
                r_rem <= VW'(rem_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= rem_sh[VW-1:0];
            end
        end
    end

    assign o_done     = (r_cnt == CW'(1));
    assign o_quotient = r_quo;

endmodule

>>> sv/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath
// Sample accumulator, millivolt scaling, segment lookup, interpolation,
// offset, hysteresis relay, configuration and output registers.
// ----------------------------------------------------------------------------
module stt_datapath #(
    parameter int SAMPLES_PER_READING = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stt_pkg::t_cmd      i_cmd,
    output stt_pkg::t_sts      o_sts,
    input  logic [9:0]         i_adc_sample,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [9:0]  o_temperature,
    output logic               o_out_of_range,
    output logic               o_relay_on
);

    localparam int SW = $clog2(SAMPLES_PER_READING * 1023 + 1);
    localparam int CW = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(SAMPLES_PER_READING - 1);
    // numerator magnitude stays below 2^14, segment widths below 128
    localparam int DW = 16;
    localparam int VW = 7;

    // sum / samples as (sum * ceil(2^k / samples)) >> k, exact for any sum below 2^SW
    localparam int AVG_SH = SW + $clog2(SAMPLES_PER_READING);
    localparam int RW     = SW + 1;
    localparam int PW     = SW + RW;
    localparam logic [RW-1:0] AVG_RECIP =
        RW'(((1 << AVG_SH) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    // configuration
    logic signed [7:0] r_offset;
    logic signed [8:0] r_upper;
    logic signed [8:0] r_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= stt_pkg::RST_TEMP_OFFSET;
            r_upper  <= stt_pkg::RST_UPPER_LIMIT;
            r_lower  <= stt_pkg::RST_LOWER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stt_pkg::CFG_TEMP_OFFSET: r_offset <= i_cfg_data[7:0];
                stt_pkg::CFG_UPPER_LIMIT: r_upper  <= i_cfg_data;
                stt_pkg::CFG_LOWER_LIMIT: r_lower  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accumulator
    logic [SW-1:0] r_sum;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.avg) begin
            // sum is averaged this cycle
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SW'(i_adc_sample);
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // average
    logic [9:0]    r_avg;
    logic [PW-1:0] avg_prod;

    assign avg_prod = PW'(r_sum) * PW'(AVG_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.avg) begin
            r_avg <= avg_prod[AVG_SH +: 10];
        end
    end

    // interpolation divider
    logic [19:0]    r_num;
    logic [19:0]    mag;
    logic [6:0]     r_d;
    logic [DW-1:0]  div_dvd;
    logic [VW-1:0]  div_dvs;
    logic           div_done;
    logic [DW-1:0]  div_quo;

    assign mag     = r_num[19] ? (~r_num + 20'd1) : r_num;
    assign div_dvd = DW'(mag);
    assign div_dvs = VW'(r_d);

    stt_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // millivolt scaling
    logic [11:0] r_mv;
    logic [19:0] prod;

    assign prod = 20'(r_avg) * 20'(stt_pkg::MV_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_mv <= prod[19:8];
        end
    end

    // segment pick: first segment whose successor starts below mv
    logic [stt_pkg::SEG_IW-1:0] seg;

    always_comb begin
        seg = stt_pkg::SEG_IW'(stt_pkg::SEG_N - 1);
        for (int i = stt_pkg::SEG_N - 2; i >= 0; i--) begin
            if ({1'b0, r_mv} > {2'b00, stt_pkg::SEG_V1[i+1]}) begin
                seg = stt_pkg::SEG_IW'(i);
            end
        end
    end

    logic signed [12:0] r_a;
    logic signed [8:0]  r_t1;
    logic [4:0]         r_dt;
    logic               r_oor;
    logic [10:0]        v1_s;
    logic [10:0]        v2_s;
    logic signed [8:0]  t1_s;
    logic signed [8:0]  t2_s;
    logic [10:0]        dv;
    logic signed [8:0]  dt;

    assign v1_s = stt_pkg::SEG_V1[seg];
    assign v2_s = stt_pkg::SEG_V2[seg];
    assign t1_s = stt_pkg::SEG_T1[seg];
    assign t2_s = stt_pkg::SEG_T2[seg];
    assign dv   = v1_s - v2_s;
    assign dt   = t2_s - t1_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg) begin
            r_a   <= $signed({2'b00, v1_s}) - $signed({1'b0, r_mv});
            r_d   <= dv[6:0];
            r_t1  <= t1_s;
            r_dt  <= dt[4:0];
            r_oor <= (r_mv < stt_pkg::MV_LO) || (r_mv > stt_pkg::MV_HI);
        end
    end

    // numerator t1*d + a*dt, divided as a magnitude by d
    logic signed [16:0] p_td;
    logic signed [18:0] p_ad;

    assign p_td = r_t1 * $signed({1'b0, r_d});
    assign p_ad = r_a * $signed({1'b0, r_dt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.num) begin
            r_num <= {{3{p_td[16]}}, p_td} + {p_ad[18], p_ad};
        end
    end

    // result, offset and thermostat
    logic [9:0]        qs;
    logic [9:0]        raw;
    logic signed [9:0] temp;
    logic              r_valid;
    logic              r_relay;

    assign qs   = {1'b0, div_quo[8:0]};
    assign raw  = r_oor ? stt_pkg::RAW_OOR : (r_num[19] ? (~qs + 10'd1) : qs);
    assign temp = $signed(raw) + $signed({{2{r_offset[7]}}, r_offset});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_relay <= 1'b0;
        end else if (i_cmd.fin) begin
            r_valid <= 1'b1;
            if (temp >= $signed({r_upper[8], r_upper})) begin
                r_relay <= 1'b1;
            end else if (temp <= $signed({r_lower[8], r_lower})) begin
                r_relay <= 1'b0;
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_temperature  <= temp;
            o_out_of_range <= r_oor;
        end
    end

    assign o_valid    = r_valid;
    assign o_relay_on = r_relay;

    assign o_sts.last     = (r_cnt == CNT_LAST);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_valid || i_ready;

endmodule

>>> sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: accepts samples and steps the datapath through one
// conversion when a reading is complete.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  stt_pkg::t_sts i_sts,
    output stt_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_AVG  = 8'b00000010,
        S_MUL  = 8'b00000100,
        S_SEG  = 8'b00001000,
        S_NUM  = 8'b00010000,
        S_DVS  = 8'b00100000,
        S_DVW  = 8'b01000000,
        S_FIN  = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.acc = i_valid;
                if (i_valid && i_sts.last) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SEG;
            end
            S_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = S_DVS;
            end
            S_DVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DVW;
            end
            S_DVW: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/sensor_temp_thermostat_top.sv
// ----------------------------------------------------------------------------
// sensor_temp_thermostat_top
// Averaging temperature sensor front end with piecewise linear
// interpolation, calibration offset and hysteresis relay control.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one 10-bit converter sample a word.
// A sample that does not complete a reading is taken without stalling the
// channel and gives no output. The SAMPLES_PER_READING-th sample starts a
// conversion: average by reciprocal multiplication, scale to millivolts,
// pick the table segment, form the interpolation numerator and divide it
// by the segment width on a bit-serial shift-subtract divider. The o_ready
// output is low from the edge that takes the last sample until the edge
// that loads the word into the output register and raises o_valid.
// Output channel (o_valid/i_ready) carries temperature, out of range flag
// and relay drive from an output register; samples are accepted while a
// word waits there. If the receiver stalls, the finished conversion waits
// until the register frees up, then the block goes back to taking samples.
// Configuration writes (index 0 offset, 1 upper, 2 lower limit) are always
// taken. Reset clears sum, count and relay and loads default limits.
// ----------------------------------------------------------------------------
module sensor_temp_thermostat_top #(
    parameter int SAMPLES_PER_READING = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [9:0]        i_adc_sample,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [9:0] o_temperature,
    output logic              o_out_of_range,
    output logic              o_relay_on,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data
);

    stt_pkg::t_cmd cmd;
    stt_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stt_datapath #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_adc_sample   (i_adc_sample),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_temperature  (o_temperature),
        .o_out_of_range (o_out_of_range),
        .o_relay_on     (o_relay_on)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor thermostat. Samples go in on a
// valid/ready channel. A scoreboard averages each group of sixteen, maps
// the average through the voltage/temperature segments, adds the offset,
// runs the relay hysteresis and checks every output word in order.
// Directed cases cover range edges, segment edges, offset and limit
// extremes. Random readings follow under several idle patterns and
// register settings, with a long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SAMPLES_PER_READING = 16;
    localparam int SEG_COUNT           = 11;
    localparam int MIN_MV              = 183;
    localparam int MAX_MV              = 1299;
    localparam int OOR_DEGREES         = 255;
    localparam int SETTLE_CYCLES       = 64;
    localparam int MAX_REPORTS         = 60;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    // segment ends in mV and the matching temperatures
    localparam int TAB_V1 [SEG_COUNT] = '{1299, 1247, 1141, 1034, 925, 816,
                                          704, 591, 476, 361, 243};
    localparam int TAB_V2 [SEG_COUNT] = '{1252, 1146, 1039, 931, 821, 710,
                                          596, 482, 367, 249, 183};
    localparam int TAB_T1 [SEG_COUNT] = '{-50, -40, -20, 0, 20, 40,
                                          60, 80, 100, 120, 140};
    localparam int TAB_T2 [SEG_COUNT] = '{-41, -21, -1, 19, 39, 59,
                                          79, 99, 119, 139, 150};

    typedef struct packed {
        logic signed [9:0] temperature;
        logic              out_of_range;
        logic              relay_on;
    } t_reading;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [9:0]        i_adc_sample;
    logic              o_valid;
    logic              i_ready;
    logic signed [9:0] o_temperature;
    logic              o_out_of_range;
    logic              o_relay_on;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [8:0]        i_cfg_data;

    // scoreboard state
    t_reading          pending_readings [$];
    int                acc_sum      = 0;
    int                acc_count    = 0;
    logic              relay_state  = 1'b0;
    logic signed [7:0] cfg_offset   = stt_pkg::RST_TEMP_OFFSET;
    logic signed [8:0] cfg_upper    = stt_pkg::RST_UPPER_LIMIT;
    logic signed [8:0] cfg_lower    = stt_pkg::RST_LOWER_LIMIT;
    int                error_count  = 0;

    int                tx_idle_pct  = 0;
    int                rx_idle_pct  = 0;
    int                stall_cycles = 0;

    sensor_temp_thermostat_top #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_adc_sample   (i_adc_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_temperature  (o_temperature),
        .o_out_of_range (o_out_of_range),
        .o_relay_on     (o_relay_on),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // temperature prediction
    // ------------------------------------------------------------------
    function automatic int degrees_of_avg(input int avg, output logic oor);
        int mv;
        int seg;
        int den;
        mv  = (avg * 825) / 256;
        oor = (mv < MIN_MV) || (mv > MAX_MV);
        if (oor) begin
            return OOR_DEGREES;
        end
        // first segment whose successor starts below mv
        seg = SEG_COUNT - 1;
        for (int i = SEG_COUNT - 2; i >= 0; i--) begin
            if (mv > TAB_V1[i + 1]) begin
                seg = i;
            end
        end
        den = TAB_V2[seg] - TAB_V1[seg];
        if (den == 0) begin
            return TAB_T1[seg];
        end
        return ((mv - TAB_V1[seg]) * (TAB_T2[seg] - TAB_T1[seg])
                + TAB_T1[seg] * den) / den;
    endfunction

    function automatic t_reading thermostat_reading(input int sum);
        t_reading r;
        logic     oor;
        int       temp;
        temp = degrees_of_avg(sum / SAMPLES_PER_READING, oor) + cfg_offset;
        if (temp >= cfg_upper) begin
            relay_state = 1'b1;
        end else if (temp <= cfg_lower) begin
            relay_state = 1'b0;
        end
        r.temperature  = temp[9:0];
        r.out_of_range = oor;
        r.relay_on     = relay_state;
        return r;
    endfunction

    function automatic int avg_for_mv(input int mv);
        return (mv * 256 + 824) / 825;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // scoreboard: register writes, accepted samples, output words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    stt_pkg::CFG_TEMP_OFFSET: cfg_offset = i_cfg_data[7:0];
                    stt_pkg::CFG_UPPER_LIMIT: cfg_upper  = i_cfg_data;
                    stt_pkg::CFG_LOWER_LIMIT: cfg_lower  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                acc_sum   = acc_sum + i_adc_sample;
                acc_count = acc_count + 1;
                if (acc_count == SAMPLES_PER_READING) begin
                    pending_readings.push_back(thermostat_reading(acc_sum));
                    acc_sum   = 0;
                    acc_count = 0;
                end
            end
            if (o_valid && i_ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("output word with no reading pending",
                                    o_temperature, 0);
                end else begin
                    want = pending_readings.pop_front();
                    if (o_temperature !== want.temperature) begin
                        report_mismatch("temperature", o_temperature, want.temperature);
                    end
                    if (o_out_of_range !== want.out_of_range) begin
                        report_mismatch("out_of_range", o_out_of_range,
                                        want.out_of_range);
                    end
                    if (o_relay_on !== want.relay_on) begin
                        report_mismatch("relay_on", o_relay_on, want.relay_on);
                    end
                end
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_cycles > 0) begin
                i_ready <= 1'b0;
                stall_cycles--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // valid stays high after acceptance; the next call drops it only for an idle gap, a drain drops it
    task automatic send_sample(input logic [9:0] value);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid      <= 1'b1;
        i_adc_sample <= value;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    // sixteen samples whose truncated mean is avg; extra lands on the last one
    task automatic send_reading(input int avg, input int extra);
        int last;
        last = (avg + extra > 1023) ? 1023 : avg + extra;
        repeat (SAMPLES_PER_READING - 1) begin
            send_sample(avg[9:0]);
        end
        send_sample(last[9:0]);
    endtask

    task automatic drain_readings();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_reading();
        int kind;
        int target;
        int spread;
        int v;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            target = $urandom_range(57, 403);
        end else if ($urandom_range(0, 1) == 1) begin
            target = $urandom_range(0, 56);
        end else begin
            target = $urandom_range(404, 1023);
        end
        spread = $urandom_range(0, 40);
        repeat (SAMPLES_PER_READING) begin
            if (kind >= 85) begin
                v = $urandom_range(0, 1023);
            end else begin
                v = target + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
            end
            send_sample(v[9:0]);
        end
    endtask

    task automatic write_random_setting();
        int         centre;
        int         width;
        logic [8:0] up;
        logic [8:0] lo;
        logic [8:0] off;
        centre = int'($urandom_range(0, 220)) - 60;
        width  = $urandom_range(0, 15);
        up     = 9'(centre + width);
        lo     = 9'(centre - width);
        case ($urandom_range(0, 9))
            0: begin
                up = 9'(centre - width);
                lo = 9'(centre + width);
            end
            1: begin
                up = 9'h0FF;
                lo = 9'h100;
            end
            2: begin
                up = 9'($urandom);
                lo = 9'($urandom);
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            off = 9'($urandom);
        end else begin
            off = 9'(int'($urandom_range(0, 198)) - 99);
        end
        write_reg(stt_pkg::CFG_TEMP_OFFSET, off);
        write_reg(stt_pkg::CFG_UPPER_LIMIT, up);
        write_reg(stt_pkg::CFG_LOWER_LIMIT, lo);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // averages either side of the valid millivolt window, reset settings
    task automatic test_conversion_range();
        send_reading(0, 0);
        send_reading(56, $urandom_range(0, 15));
        send_reading(57, $urandom_range(0, 15));
        send_reading(403, $urandom_range(0, 15));
        send_reading(404, $urandom_range(0, 15));
        send_reading(1023, 0);
        drain_readings();
    endtask

    task automatic test_segment_edges();
        for (int i = 0; i < SEG_COUNT; i++) begin
            send_reading(avg_for_mv(TAB_V1[i]), $urandom_range(0, 15));
            send_reading(avg_for_mv(TAB_V2[i]), $urandom_range(0, 15));
        end
        drain_readings();
    endtask

    task automatic test_offset_extremes();
        write_reg(stt_pkg::CFG_TEMP_OFFSET, 9'h07F);
        send_reading(0, 0);
        send_reading(57, 0);
        drain_readings();
        write_reg(stt_pkg::CFG_TEMP_OFFSET, 9'h080);
        send_reading(403, 0);
        send_reading(1023, 0);
        drain_readings();
        // upper data bit is not part of the offset
        write_reg(stt_pkg::CFG_TEMP_OFFSET, 9'h163);
        send_reading(200, 0);
        drain_readings();
        write_reg(stt_pkg::CFG_TEMP_OFFSET, 9'(-99));
        send_reading(300, 0);
        drain_readings();
        write_reg(stt_pkg::CFG_TEMP_OFFSET, 9'h000);
    endtask

    task automatic test_thermostat();
        int   t_hot;
        int   t_mid;
        int   t_cold;
        logic oor;
        t_hot  = degrees_of_avg(150, oor);
        t_mid  = degrees_of_avg(250, oor);
        t_cold = degrees_of_avg(350, oor);
        write_reg(stt_pkg::CFG_UPPER_LIMIT, 9'(t_hot));
        write_reg(stt_pkg::CFG_LOWER_LIMIT, 9'(t_cold));
        // on exactly at the upper limit, off exactly at the lower, hold between
        send_reading(250, 0);
        send_reading(150, 0);
        send_reading(250, 0);
        send_reading(350, 0);
        send_reading(250, 0);
        drain_readings();
        // lower limit above upper limit
        write_reg(stt_pkg::CFG_UPPER_LIMIT, 9'(t_cold));
        write_reg(stt_pkg::CFG_LOWER_LIMIT, 9'(t_hot));
        send_reading(250, 0);
        send_reading(400, 0);
        drain_readings();
        write_reg(stt_pkg::CFG_UPPER_LIMIT, 9'h0FF);
        write_reg(stt_pkg::CFG_LOWER_LIMIT, 9'h100);
        send_reading(0, 0);
        send_reading(250, 0);
        drain_readings();
        write_reg(stt_pkg::CFG_UPPER_LIMIT, 9'h100);
        send_reading(350, 0);
        drain_readings();
        write_reg(stt_pkg::CFG_UPPER_LIMIT, 9'h0FF);
        write_reg(stt_pkg::CFG_LOWER_LIMIT, 9'h0FF);
        send_reading(250, 0);
        drain_readings();
        if (t_mid == t_hot) begin
            report_mismatch("thermostat test points not distinct", t_mid, t_hot);
        end
    endtask

    // writes to the spare index must change nothing
    task automatic test_unused_index();
        write_reg(stt_pkg::CFG_TEMP_OFFSET, 9'h000);
        write_reg(stt_pkg::CFG_UPPER_LIMIT, 9'(35));
        write_reg(stt_pkg::CFG_LOWER_LIMIT, 9'(30));
        write_reg(CFG_UNUSED, 9'h1FF);
        send_reading(300, $urandom_range(0, 15));
        drain_readings();
        write_reg(CFG_UNUSED, 9'h000);
    endtask

    // long receiver hold-off while samples keep coming; input must stall
    task automatic test_output_stall();
        stall_cycles = 300;
        repeat (5) send_random_reading();
        drain_readings();
    endtask

    task automatic test_random(input int readings);
        int left;
        int burst;
        left = readings;
        while (left > 0) begin
            drain_readings();
            write_random_setting();
            burst = $urandom_range(4, 10);
            if (burst > left) burst = left;
            repeat (burst) send_random_reading();
            left -= burst;
        end
        drain_readings();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_adc_sample <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 16;
        rx_idle_pct = 57;
        test_conversion_range();
        test_segment_edges();
        test_offset_extremes();
        test_thermostat();
        test_unused_index();
        test_random(16);
        test_output_stall();

        tx_idle_pct = 57;
        rx_idle_pct = 16;
        test_random(16);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(16);
        test_output_stall();

        drain_readings();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
sv/stt_pkg.sv
sv/stt_div.sv
sv/stt_datapath.sv
sv/stt_ctrl.sv
sv/sensor_temp_thermostat_top.sv
tb/tb_top.sv
